// File: rtl/gb3_pkg.sv
`timescale 1ns / 1ps
package gb3_pkg;

    localparam int MAX_WIDTH_DEFAULT = 2048;

    localparam int WIDTH_BITS  = 12;
    localparam int HEIGHT_BITS = 16;
    localparam int ROW_BITS    = HEIGHT_BITS + 1;
    localparam int CHAN_BITS   = 8;
    localparam int PIXEL_BITS  = 3 * CHAN_BITS;
    localparam int SUM_BITS    = CHAN_BITS + 4;

    localparam int MIN_DIM = 2;
    localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH  = 12'd640;
    localparam logic [HEIGHT_BITS-1:0] RESET_HEIGHT = 16'd480;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 4'd0,
        REG_IMAGE_HEIGHT = 4'd1
    } reg_index_t;

    // 1 2 1 / 2 4 2 / 1 2 1, row-major
    localparam logic [2:0] KERNEL_WEIGHT [9] = '{
        3'd1, 3'd2, 3'd1,
        3'd2, 3'd4, 3'd2,
        3'd1, 3'd2, 3'd1
    };

    // Per-request classification handed from the front to the back
    typedef struct packed {
        logic exists;
        logic up_ok;
        logic down_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } tap_ctl_t;

endpackage

// File: rtl/gaussian_blur_3x3_rgb_unit.sv
`timescale 1ns / 1ps
// Order: the result for pixel k reaches the output register after the request carrying
// item k + W + 1 has passed the queue, the read stage and the window stage.
// Throughput: one request per cycle while in_stall is low; the line buffer is one RAM
// with one read and one write port, read once and written once per request.
// Reset: width 640, height 480, counters and pipeline valids cleared; the line buffer
// is not cleared, since unwritten entries only ever feed taps outside the image.
module gaussian_blur_3x3_rgb_unit #(
    parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gb3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [gb3_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [gb3_pkg::CHAN_BITS-1:0]       red_in,
    input  logic [gb3_pkg::CHAN_BITS-1:0]       green_in,
    input  logic [gb3_pkg::CHAN_BITS-1:0]       blue_in,
    input  logic                                is_pad,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [gb3_pkg::CHAN_BITS-1:0]       red_out,
    output logic [gb3_pkg::CHAN_BITS-1:0]       green_out,
    output logic [gb3_pkg::CHAN_BITS-1:0]       blue_out,
    output logic                                frame_last
);

    localparam int ColW   = $clog2(MAX_WIDTH);
    localparam int PixW   = gb3_pkg::PIXEL_BITS;
    localparam int CtlW   = $bits(gb3_pkg::tap_ctl_t);
    localparam int EntryW = ColW + PixW + CtlW;

    logic              q_push, q_pop, q_full, q_head_valid;
    logic [ColW-1:0]   push_col, head_col;
    logic [PixW-1:0]   push_pix, head_pix;
    gb3_pkg::tap_ctl_t push_ctl, head_ctl;
    logic [EntryW-1:0] q_push_data, q_head_data;

    gb3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .is_pad     (is_pad),
        .queue_full (q_full),
        .push       (q_push),
        .push_col   (push_col),
        .push_pix   (push_pix),
        .push_ctl   (push_ctl)
    );

    assign q_push_data = {push_col, push_pix, push_ctl};

    gb3_queue #(
        .WIDTH (EntryW),
        .DEPTH (gb3_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .pop        (q_pop),
        .head_data  (q_head_data),
        .head_valid (q_head_valid),
        .full       (q_full)
    );

    assign head_col = q_head_data[EntryW-1 -: ColW];
    assign head_pix = q_head_data[CtlW +: PixW];
    assign head_ctl = gb3_pkg::tap_ctl_t'(q_head_data[CtlW-1:0]);

    gb3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_col   (head_col),
        .head_pix   (head_pix),
        .head_ctl   (head_ctl),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .frame_last (frame_last)
    );

    // A held result freezes the back end, so nothing leaves the queue
    a_no_pop_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !q_pop)
        else $error("queue popped while the output was held");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("queue popped while empty");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> q_head_valid)
        else $error("pushed request not visible at the queue head");

endmodule

// File: rtl/gb3_ram.sv
`timescale 1ns / 1ps
module gb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/gb3_queue.sv
`timescale 1ns / 1ps
module gb3_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = gb3_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             head_valid,
    output logic             full
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_data  = entry_reg[rd_ptr_reg];
    assign head_valid = count_reg != '0;
    assign full       = count_reg == CntW'(DEPTH);

endmodule

// File: rtl/gb3_front.sv
`timescale 1ns / 1ps
module gb3_front #(
    parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [gb3_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [gb3_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [gb3_pkg::CHAN_BITS-1:0]          red_in,
    input  logic [gb3_pkg::CHAN_BITS-1:0]          green_in,
    input  logic [gb3_pkg::CHAN_BITS-1:0]          blue_in,
    input  logic                                   is_pad,
    input  logic                                   queue_full,
    output logic                                   push,
    output logic [$clog2(MAX_WIDTH)-1:0]           push_col,
    output logic [gb3_pkg::PIXEL_BITS-1:0]         push_pix,
    output gb3_pkg::tap_ctl_t                      push_ctl
);

    localparam int ColW = $clog2(MAX_WIDTH);
    localparam int EffW = $clog2(MAX_WIDTH + 1);
    localparam int RowW = gb3_pkg::ROW_BITS;
    localparam int WidW = gb3_pkg::WIDTH_BITS;
    localparam int HgtW = gb3_pkg::HEIGHT_BITS;

    logic [WidW-1:0] width_reg, width_next;
    logic [HgtW-1:0] height_reg, height_next;
    logic [ColW-1:0] col_reg, col_next;
    logic [RowW-1:0] row_reg, row_next;

    logic [EffW-1:0] eff_w;
    logic [HgtW-1:0] eff_h;
    logic [RowW-1:0] eff_h_row;
    logic            in_frame;
    logic            accept;
    logic            col_nz;
    logic [RowW-1:0] tr;
    logic [ColW-1:0] tc;
    logic            col_wrap;
    logic            cfg_we;
    gb3_pkg::tap_ctl_t ctl;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        priority if (int'(width_reg) < gb3_pkg::MIN_DIM)
        begin
            eff_w = EffW'(gb3_pkg::MIN_DIM);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            eff_w = EffW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EffW'(width_reg);
        end
        eff_h = (int'(height_reg) < gb3_pkg::MIN_DIM) ? HgtW'(gb3_pkg::MIN_DIM) : height_reg;
    end

    assign eff_h_row = RowW'(eff_h);
    assign in_frame  = row_reg < eff_h_row;
    assign in_stall  = queue_full;
    assign accept    = in_valid && !in_stall;
    // drop pads that arrive while frame pixels are still expected
    assign push      = accept && !(in_frame && is_pad);
    assign push_pix  = in_frame ? {blue_in, green_in, red_in} : '0;
    assign push_col  = col_reg;

    // Locate the pixel whose window completes with this request
    assign col_nz = col_reg != '0;
    assign tr     = col_nz ? row_reg - RowW'(1) : row_reg - RowW'(2);
    assign tc     = col_nz ? col_reg - ColW'(1) : ColW'(eff_w - EffW'(1));

    always_comb
    begin
        ctl.exists   = col_nz ? (row_reg >= RowW'(1)) : (row_reg >= RowW'(2));
        ctl.up_ok    = tr != '0;
        ctl.down_ok  = (tr + RowW'(1)) < eff_h_row;
        ctl.left_ok  = tc != '0;
        ctl.right_ok = (EffW'(tc) + EffW'(1)) < eff_w;
        ctl.last     = ctl.exists && (tr == eff_h_row - RowW'(1))
                       && (EffW'(tc) == eff_w - EffW'(1));
    end

    assign push_ctl = ctl;
    assign col_wrap = (EffW'(col_reg) + EffW'(1)) >= eff_w;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                gb3_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_data[WidW-1:0];
                gb3_pkg::REG_IMAGE_HEIGHT: height_next = cfg_data[HgtW-1:0];
                default: ;
            endcase
            if (cfg_index == gb3_pkg::REG_IMAGE_WIDTH
                || cfg_index == gb3_pkg::REG_IMAGE_HEIGHT)
            begin
                col_next = '0;
                row_next = '0;
            end
        end
        else if (push)
        begin
            priority if (ctl.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_wrap)
            begin
                col_next = '0;
                row_next = row_reg + RowW'(1);
            end
            else
            begin
                col_next = col_reg + ColW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gb3_pkg::RESET_WIDTH;
            height_reg <= gb3_pkg::RESET_HEIGHT;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

// File: rtl/gb3_back.sv
`timescale 1ns / 1ps
module gb3_back #(
    parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               head_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0]       head_col,
    input  logic [gb3_pkg::PIXEL_BITS-1:0]     head_pix,
    input  gb3_pkg::tap_ctl_t                  head_ctl,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [gb3_pkg::CHAN_BITS-1:0]      red_out,
    output logic [gb3_pkg::CHAN_BITS-1:0]      green_out,
    output logic [gb3_pkg::CHAN_BITS-1:0]      blue_out,
    output logic                               frame_last
);

    localparam int ColW  = $clog2(MAX_WIDTH);
    localparam int PixW  = gb3_pkg::PIXEL_BITS;
    localparam int ChW   = gb3_pkg::CHAN_BITS;
    localparam int SumW  = gb3_pkg::SUM_BITS;
    localparam int LineW = 2 * PixW;

    logic advance;

    // Read stage: line buffer data arrives alongside the request
    logic              s1_valid_reg, s1_valid_next;
    logic [ColW-1:0]   s1_col_reg;
    logic [PixW-1:0]   s1_pix_reg;
    gb3_pkg::tap_ctl_t s1_ctl_reg;
    logic              byp_hit_reg;
    logic [LineW-1:0]  byp_data_reg;

    logic              lb_wr_en;
    logic [LineW-1:0]  lb_wr_data;
    logic [LineW-1:0]  lb_rd_data;
    logic [LineW-1:0]  line_rd;
    logic [PixW-1:0]   up_pix, mid_pix;

    // Window stage
    logic [PixW-1:0]   win_reg [9];
    logic [PixW-1:0]   win_next [9];
    logic              w_valid_reg, w_valid_next;
    gb3_pkg::tap_ctl_t w_ctl_reg;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [ChW-1:0]    red_reg, green_reg, blue_reg;
    logic              last_reg;
    logic [SumW-1:0]   sum [3];
    logic              emit;

    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && head_valid;

    assign lb_wr_en   = advance && s1_valid_reg;
    assign line_rd    = byp_hit_reg ? byp_data_reg : lb_rd_data;
    assign up_pix     = line_rd[LineW-1:PixW];
    assign mid_pix    = line_rd[PixW-1:0];
    // shift the column: middle row moves up, new pixel becomes middle
    assign lb_wr_data = {mid_pix, s1_pix_reg};

    gb3_ram #(
        .WIDTH (LineW),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (lb_wr_en),
        .wr_addr (s1_col_reg),
        .wr_data (lb_wr_data),
        .rd_en   (pop),
        .rd_addr (head_col),
        .rd_data (lb_rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_col_reg   <= head_col;
            s1_pix_reg   <= head_pix;
            s1_ctl_reg   <= head_ctl;
            // forward a write to the same column that lands with this read
            byp_hit_reg  <= lb_wr_en && (s1_col_reg == head_col);
            byp_data_reg <= lb_wr_data;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (advance && s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r * 3 + 0] = win_reg[r * 3 + 1];
                win_next[r * 3 + 1] = win_reg[r * 3 + 2];
            end
            win_next[2] = up_pix;
            win_next[5] = mid_pix;
            win_next[8] = s1_pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            win_reg[i] <= win_next[i];
        end
        if (advance && s1_valid_reg)
        begin
            w_ctl_reg <= s1_ctl_reg;
        end
    end

    // Weighted sum per channel; taps outside the image take the centre pixel
    always_comb
    begin
        logic            outside;
        logic [PixW-1:0] tap;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = '0;
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                outside = (r == 0 && !w_ctl_reg.up_ok) || (r == 2 && !w_ctl_reg.down_ok)
                          || (c == 0 && !w_ctl_reg.left_ok) || (c == 2 && !w_ctl_reg.right_ok);
                tap = outside ? win_reg[4] : win_reg[r * 3 + c];
                for (int ch = 0; ch < 3; ch++)
                begin
                    sum[ch] = sum[ch] + SumW'(tap[ch * ChW +: ChW])
                              * SumW'(gb3_pkg::KERNEL_WEIGHT[r * 3 + c]);
                end
            end
        end
    end

    assign emit = w_valid_reg && w_ctl_reg.exists;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        w_valid_next   = w_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            s1_valid_next  = head_valid;
            w_valid_next   = s1_valid_reg;
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            red_reg   <= sum[0][SumW-1:4];
            green_reg <= sum[1][SumW-1:4];
            blue_reg  <= sum[2][SumW-1:4];
            last_reg  <= w_ctl_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            w_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            w_valid_reg   <= w_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = red_reg;
    assign green_out  = green_reg;
    assign blue_out   = blue_reg;
    assign frame_last = last_reg;

endmodule

// File: sim/gaussian_blur_3x3_rgb_unit_tb.sv
`timescale 1ns / 1ps
module gaussian_blur_3x3_rgb_unit_tb;

    localparam int MAX_COLUMNS      = gb3_pkg::MAX_WIDTH_DEFAULT;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_REQUESTS  = 850;
    localparam int CLAMP_PROBE      = 96;
    localparam int LONG_ROW         = 150;
    localparam logic [gb3_pkg::CFG_DATA_BITS-1:0] LONG_ROW_DATA =
        LONG_ROW[gb3_pkg::CFG_DATA_BITS-1:0];
    localparam longint TIMEOUT_NS   = 20_000_000;
    localparam logic [gb3_pkg::CFG_INDEX_BITS-1:0] UNMAPPED_REG = 4'hF;

    typedef struct packed {
        logic [gb3_pkg::CHAN_BITS-1:0] red;
        logic [gb3_pkg::CHAN_BITS-1:0] green;
        logic [gb3_pkg::CHAN_BITS-1:0] blue;
        logic                          last;
    } blur_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [gb3_pkg::CFG_INDEX_BITS-1:0] cfg_index = gb3_pkg::REG_IMAGE_WIDTH;
    logic [gb3_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic [gb3_pkg::CHAN_BITS-1:0]      red_in = '0;
    logic [gb3_pkg::CHAN_BITS-1:0]      green_in = '0;
    logic [gb3_pkg::CHAN_BITS-1:0]      blue_in = '0;
    logic                               is_pad = 1'b0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic [gb3_pkg::CHAN_BITS-1:0]      red_out;
    logic [gb3_pkg::CHAN_BITS-1:0]      green_out;
    logic [gb3_pkg::CHAN_BITS-1:0]      blue_out;
    logic                               frame_last;

    // Predicted block state
    logic [gb3_pkg::WIDTH_BITS-1:0]  blur_width_reg = gb3_pkg::RESET_WIDTH;
    logic [gb3_pkg::HEIGHT_BITS-1:0] blur_height_reg = gb3_pkg::RESET_HEIGHT;
    bit [gb3_pkg::PIXEL_BITS-1:0]    blur_upper [MAX_COLUMNS];
    bit [gb3_pkg::PIXEL_BITS-1:0]    blur_middle [MAX_COLUMNS];
    bit [gb3_pkg::PIXEL_BITS-1:0]    blur_window [9];
    int unsigned                     blur_col = 0;
    int unsigned                     blur_row = 0;
    int unsigned                     blur_emitted = 0;

    blur_result_t expected_blur [$];
    blur_result_t head_blur;
    int unsigned  counted_requests = 0;
    int           error_count = 0;
    int           gap_odds = 0;
    int           stall_odds = 0;
    int           stall_hold = 0;

    gaussian_blur_3x3_rgb_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .is_pad     (is_pad),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .frame_last (frame_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic restart_blur_frame();
        blur_col = 0;
        blur_row = 0;
        blur_emitted = 0;
    endtask

    task automatic apply_blur_reg(input logic [gb3_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [gb3_pkg::CFG_DATA_BITS-1:0] data);
        if (idx == gb3_pkg::REG_IMAGE_WIDTH)
        begin
            blur_width_reg = data[gb3_pkg::WIDTH_BITS-1:0];
            restart_blur_frame();
        end
        else if (idx == gb3_pkg::REG_IMAGE_HEIGHT)
        begin
            blur_height_reg = data[gb3_pkg::HEIGHT_BITS-1:0];
            restart_blur_frame();
        end
    endtask

    task automatic predict_blur(input logic [gb3_pkg::CHAN_BITS-1:0] r, g, b,
                                input logic pad);
        int unsigned w, h, col, row, tr, tc, sum, shifted;
        bit [gb3_pkg::PIXEL_BITS-1:0] pix, tap;
        bit exists, vu, vd, vl, vr, outside, last;
        logic [gb3_pkg::CHAN_BITS-1:0] blurred [3];
        blur_result_t res;
        w = (int'(blur_width_reg) < gb3_pkg::MIN_DIM) ? gb3_pkg::MIN_DIM :
            ((int'(blur_width_reg) > MAX_COLUMNS) ? MAX_COLUMNS : int'(blur_width_reg));
        h = (int'(blur_height_reg) < gb3_pkg::MIN_DIM) ? gb3_pkg::MIN_DIM :
            int'(blur_height_reg);
        col = blur_col;
        row = blur_row;
        pix = '0;
        // pads are dropped while the frame still wants pixels; during drain all count
        if (row < h)
        begin
            if (pad)
                return;
            pix = {b, g, r};
        end
        counted_requests++;

        for (int rr = 0; rr < 3; rr++)
        begin
            blur_window[rr * 3]     = blur_window[rr * 3 + 1];
            blur_window[rr * 3 + 1] = blur_window[rr * 3 + 2];
        end
        blur_window[2] = blur_upper[col];
        blur_window[5] = blur_middle[col];
        blur_window[8] = pix;
        blur_upper[col] = blur_middle[col];
        blur_middle[col] = pix;

        // the window centre trails the incoming position by one row and one column
        if (col >= 1)
        begin
            exists = row >= 1;
            tr = row - 1;
            tc = col - 1;
        end
        else
        begin
            exists = row >= 2;
            tr = row - 2;
            tc = w - 1;
        end

        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
        end
        blur_col = col;
        blur_row = row;
        if (!exists)
            return;

        vu = tr > 0;
        vd = tr + 1 < h;
        vl = tc > 0;
        vr = tc + 1 < w;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = 0;
            for (int rr = 0; rr < 3; rr++)
                for (int cc = 0; cc < 3; cc++)
                begin
                    outside = (rr == 0 && !vu) || (rr == 2 && !vd) ||
                              (cc == 0 && !vl) || (cc == 2 && !vr);
                    tap = outside ? blur_window[4] : blur_window[rr * 3 + cc];
                    sum += ((rr == 1) ? 2 : 1) * ((cc == 1) ? 2 : 1) * tap[8 * ch +: 8];
                end
            shifted = sum >> 4;
            blurred[ch] = shifted[gb3_pkg::CHAN_BITS-1:0];
        end

        last = blur_emitted == h * w - 1;
        blur_emitted++;
        res.red = blurred[0];
        res.green = blurred[1];
        res.blue = blurred[2];
        res.last = last;
        expected_blur.push_back(res);
        if (last)
            restart_blur_frame();
    endtask

    function automatic logic [gb3_pkg::CHAN_BITS-1:0] rand_channel();
        logic [31:0] draw;
        draw = $urandom;
        unique case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return draw[gb3_pkg::CHAN_BITS-1:0];
        endcase
    endfunction

    task automatic send_pixel(input logic [gb3_pkg::CHAN_BITS-1:0] r, g, b,
                              input logic pad);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        is_pad <= pad;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_blur(r, g, b, pad);
    endtask

    // hold the input idle until every predicted result is out, then let the pipe empty
    task automatic settle_pipeline();
        in_valid <= 1'b0;
        while (expected_blur.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gb3_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [gb3_pkg::CFG_DATA_BITS-1:0] data);
        settle_pipeline();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        apply_blur_reg(idx, data);
    endtask

    task automatic stream_frame(input int unsigned pixels, input int unsigned drains,
                                input int noise_odds);
        for (int i = 0; i < pixels; i++)
        begin
            if (noise_odds != 0 && $urandom_range(1, noise_odds) == 1)
                send_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b1);
            send_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0);
        end
        // mostly pads; a real pixel here counts as drain too
        for (int i = 0; i < drains; i++)
            send_pixel(rand_channel(), rand_channel(), rand_channel(),
                       $urandom_range(0, 3) != 0);
    endtask

    task automatic pick_geometry(output int unsigned w, output int unsigned h);
        int unsigned wr, hr;
        logic [31:0] wr_word;
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
        h = $urandom_range(2, 8);
        wr = w;
        hr = h;
        if ($urandom_range(0, 15) == 0)
        begin
            wr = $urandom_range(0, 1);
            w = gb3_pkg::MIN_DIM;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            hr = $urandom_range(0, 1);
            h = gb3_pkg::MIN_DIM;
        end
        // upper data bits carry no meaning for the width register
        wr_word = ($urandom_range(0, 15) << gb3_pkg::WIDTH_BITS) | wr;
        write_reg(gb3_pkg::REG_IMAGE_WIDTH, wr_word[gb3_pkg::CFG_DATA_BITS-1:0]);
        write_reg(gb3_pkg::REG_IMAGE_HEIGHT, hr[gb3_pkg::CFG_DATA_BITS-1:0]);
    endtask

    task automatic test_clamped_minimum();
        gap_odds = 4;
        stall_odds = 4;
        write_reg(gb3_pkg::REG_IMAGE_WIDTH, 16'd1);
        write_reg(gb3_pkg::REG_IMAGE_HEIGHT, 16'd0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h5A, 8'hA5, 8'h3C, 1'b1);
        send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        // pad after the last result belongs to the next frame
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    endtask

    task automatic test_unmapped_register();
        write_reg(gb3_pkg::REG_IMAGE_WIDTH, 16'd3);
        write_reg(gb3_pkg::REG_IMAGE_HEIGHT, 16'd3);
        for (int i = 0; i < 6; i++)
            send_pixel((i % 2) ? 8'hFF : 8'h00, 8'hFF, (i % 3) ? 8'h00 : 8'hFF, 1'b0);
        // a write to an unused index must not disturb the frame position
        write_reg(UNMAPPED_REG, 16'hFFFF);
        stream_frame(3, 4, 0);
    endtask

    task automatic test_long_rows();
        gap_odds = 0;
        stall_odds = 6;
        // oversized width clamps to the widest row, so no result may appear yet
        write_reg(gb3_pkg::REG_IMAGE_WIDTH, 16'h0FFF);
        write_reg(gb3_pkg::REG_IMAGE_HEIGHT, 16'd2);
        stream_frame(CLAMP_PROBE, 0, 0);
        write_reg(gb3_pkg::REG_IMAGE_WIDTH, LONG_ROW_DATA);
        stream_frame(2 * LONG_ROW, LONG_ROW + 1, 40);
        write_reg(gb3_pkg::REG_IMAGE_WIDTH, 16'd2);
        write_reg(gb3_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
        stream_frame(24, 0, 4);
    endtask

    task automatic test_random_frames();
        int unsigned goal = counted_requests + RANDOM_REQUESTS;
        int unsigned w, h;
        int noise;
        while (counted_requests < goal)
        begin
            gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 20);
            stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 20);
            noise = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(3, 15);
            pick_geometry(w, h);
            repeat ($urandom_range(1, 2))
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    // cut the frame short, among the pixels or during the drain
                    if ($urandom_range(0, 1) == 0)
                        stream_frame($urandom_range(1, w * h - 1), 0, noise);
                    else
                        stream_frame(w * h, $urandom_range(0, w), noise);
                end
                else
                begin
                    stream_frame(w * h, w + 1, noise);
                    repeat ($urandom_range(0, 2))
                        send_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b1);
                end
            end
        end
    endtask

    task automatic test_quiet_tail();
        int unsigned w, h;
        gap_odds = 0;
        stall_odds = 0;
        pick_geometry(w, h);
        repeat (2) stream_frame(w * h, w + 1, 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] expected_value,
                               input logic [31:0] actual_value);
        if (actual_value !== expected_value)
        begin
            $error("%s: expected %0d, actual %0d", name, expected_value, actual_value);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_hold != 0)
            stall_hold <= stall_hold - 1;
        else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        begin
            out_stall <= 1'b1;
            stall_hold <= $urandom_range(0, 12);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_blur.size() == 0)
            begin
                $error("unexpected result: red %0d green %0d blue %0d frame_last %0d",
                       red_out, green_out, blue_out, frame_last);
                error_count++;
            end
            else
            begin
                head_blur = expected_blur.pop_front();
                check_field("red_out", 32'(head_blur.red), 32'(red_out));
                check_field("green_out", 32'(head_blur.green), 32'(green_out));
                check_field("blue_out", 32'(head_blur.blue), 32'(blue_out));
                check_field("frame_last", 32'(head_blur.last), 32'(frame_last));
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_clamped_minimum();
        test_unmapped_register();
        test_long_rows();
        test_random_frames();
        test_quiet_tail();
        settle_pipeline();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/gb3_pkg.sv
rtl/gb3_ram.sv
rtl/gb3_queue.sv
rtl/gb3_front.sv
rtl/gb3_back.sv
rtl/gaussian_blur_3x3_rgb_unit.sv
sim/gaussian_blur_3x3_rgb_unit_tb.sv
